// ===== hw/rtl/dwfs_pkg.sv =====
`default_nettype none

package dwfs_pkg;

  localparam int unsigned NUM_SLOTS_DEF   = 8;
  localparam int unsigned DELAY_BITS_DEF  = 16;
  localparam int unsigned RANDOM_BITS_DEF = 32;

  // field widths on the stream ports
  localparam int unsigned ACTION_BITS    = 3;
  localparam int unsigned FACE_BITS      = 6;
  localparam int unsigned DELAY_IN_BITS  = 16;
  localparam int unsigned MASK_BITS      = 64;
  localparam int unsigned RANDOM_IN_BITS = 32;
  localparam int unsigned STATUS_BITS    = 2;
  localparam int unsigned WSUM_OUT_BITS  = 22;

  // input tdata layout, lowest field first
  localparam int unsigned OFS_FACE  = 0;
  localparam int unsigned OFS_DELAY = OFS_FACE + FACE_BITS;
  localparam int unsigned OFS_MASK  = OFS_DELAY + DELAY_IN_BITS;
  localparam int unsigned OFS_RND   = OFS_MASK + MASK_BITS;
  localparam int unsigned S_TDATA_RAW = OFS_RND + RANDOM_IN_BITS;
  localparam int unsigned S_TDATA_W   = ((S_TDATA_RAW + 7) / 8) * 8;
  localparam int unsigned S_TUSER_W   = ACTION_BITS;

  // output tdata layout
  localparam int unsigned M_TDATA_RAW = FACE_BITS + WSUM_OUT_BITS;
  localparam int unsigned M_TDATA_W   = ((M_TDATA_RAW + 7) / 8) * 8;
  localparam int unsigned M_TUSER_W   = STATUS_BITS;

  // random word is multiplied in slices of this many bits, one slice a cycle
  localparam int unsigned CHUNK_BITS = 16;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_ADD    = 3'd0,
    ACT_REMOVE = 3'd1,
    ACT_RECORD = 3'd2,
    ACT_EXPIRE = 3'd3,
    ACT_SELECT = 3'd4
  } action_e;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_OK     = 2'd0,
    STAT_ABSENT = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_NONE   = 2'd3
  } status_e;

  typedef struct packed {
    logic load;
    logic apply;
    logic wsum;
    logic mul_step;
    logic pick;
    logic acc;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_select;
    logic pick_none;
    logic found;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/delay_weighted_face_selector_unit.sv =====
// Table items (add, remove, record, expire) pass the states apply, weight sum and done;
// done loads the result once the output register is free. Select adds
// ceil(RANDOM_BITS/16) multiply steps, then walks the faces with one minimum-tree step and
// one accumulate step per face, plus one more minimum-tree step when none qualifies.
// One item at a time; s_axis_tready returns once the result is loaded, even if it waits.
// rst_ni is asynchronous, active low: clears valid bits, face count, delay total, handshake.
`default_nettype none

module delay_weighted_face_selector_unit #(
  parameter int unsigned NUM_SLOTS   = dwfs_pkg::NUM_SLOTS_DEF,
  parameter int unsigned DELAY_BITS  = dwfs_pkg::DELAY_BITS_DEF,
  parameter int unsigned RANDOM_BITS = dwfs_pkg::RANDOM_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // face_id, delay_ms, eligible_mask, random_value, zero pad
  input  wire logic [dwfs_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // action
  input  wire logic [dwfs_pkg::S_TUSER_W-1:0] s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // chosen_face, weight_sum, zero pad
  output logic [dwfs_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  // status
  output logic [dwfs_pkg::M_TUSER_W-1:0]      m_axis_tuser
);
  import dwfs_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  dwfs_ctrl #(
    .RANDOM_BITS (RANDOM_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  dwfs_datapath #(
    .NUM_SLOTS   (NUM_SLOTS),
    .DELAY_BITS  (DELAY_BITS),
    .RANDOM_BITS (RANDOM_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .stat_o     (dp_stat),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/dwfs_ctrl.sv =====
`default_nettype none

module dwfs_ctrl #(
  parameter int unsigned RANDOM_BITS = dwfs_pkg::RANDOM_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_tvalid_i,
  output logic                    s_tready_o,
  input  wire dwfs_pkg::dp_stat_t stat_i,
  output dwfs_pkg::dp_cmd_t       cmd_o
);
  import dwfs_pkg::*;

  localparam int unsigned NCH  = (RANDOM_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int unsigned MC_W = (NCH > 1) ? $clog2(NCH) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPLY,
    S_WSUM,
    S_MUL,
    S_PICK,
    S_ACC,
    S_DONE
  } state_e;

  state_e          state_q, state_d;
  logic            ready_q, ready_d;
  logic [MC_W-1:0] mcnt_q, mcnt_d;

  always_comb begin
    state_d = state_q;
    ready_d = ready_q;
    mcnt_d  = mcnt_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (ready_q && s_tvalid_i) begin
          cmd_o.load = 1'b1;
          ready_d    = 1'b0;
          state_d    = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = S_WSUM;
      end
      S_WSUM: begin
        cmd_o.wsum = 1'b1;
        mcnt_d     = '0;
        state_d    = stat_i.is_select ? S_MUL : S_DONE;
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        mcnt_d         = mcnt_q + 1'b1;
        if (mcnt_q == MC_W'(NCH - 1)) begin
          state_d = S_PICK;
        end
      end
      S_PICK: begin
        cmd_o.pick = 1'b1;
        state_d    = stat_i.pick_none ? S_DONE : S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = stat_i.found ? S_DONE : S_PICK;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          ready_d        = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
      mcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      ready_q <= ready_d;
      mcnt_q  <= mcnt_d;
    end
  end

  assign s_tready_o = ready_q;

endmodule

`default_nettype wire

// ===== hw/rtl/dwfs_datapath.sv =====
`default_nettype none

module dwfs_datapath #(
  parameter int unsigned NUM_SLOTS   = dwfs_pkg::NUM_SLOTS_DEF,
  parameter int unsigned DELAY_BITS  = dwfs_pkg::DELAY_BITS_DEF,
  parameter int unsigned RANDOM_BITS = dwfs_pkg::RANDOM_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire dwfs_pkg::dp_cmd_t                 cmd_i,
  output dwfs_pkg::dp_stat_t                     stat_o,
  input  wire logic [dwfs_pkg::S_TDATA_W-1:0]    s_tdata_i,
  input  wire logic [dwfs_pkg::S_TUSER_W-1:0]    s_tuser_i,
  output logic                                   m_tvalid_o,
  input  wire logic                              m_tready_i,
  output logic [dwfs_pkg::M_TDATA_W-1:0]         m_tdata_o,
  output logic [dwfs_pkg::M_TUSER_W-1:0]         m_tuser_o
);
  import dwfs_pkg::*;

  localparam int unsigned SLOT_W = $clog2(NUM_SLOTS);
  localparam int unsigned CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int unsigned TD_W   = DELAY_BITS + SLOT_W;
  localparam int unsigned WS_W   = DELAY_BITS + 2 * SLOT_W;
  localparam int unsigned NCH    = (RANDOM_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int unsigned RND_W  = NCH * CHUNK_BITS;
  localparam int unsigned PW     = RND_W + WS_W + 1;
  localparam int unsigned KEY_W  = DELAY_BITS + FACE_BITS;
  localparam int unsigned P      = 1 << SLOT_W;

  // latched item
  action_e                act_q;
  logic [FACE_BITS-1:0]   face_q;
  logic [DELAY_BITS-1:0]  din_q;
  logic [MASK_BITS-1:0]   mask_q;
  logic [RND_W-1:0]       rnd_q;

  // face table
  logic [NUM_SLOTS-1:0]   valid_q;
  logic [FACE_BITS-1:0]   face_tab_q [NUM_SLOTS];
  logic [DELAY_BITS-1:0]  dly_q      [NUM_SLOTS];
  logic [TD_W-1:0]        total_q;
  logic [CNT_W-1:0]       cnt_q;

  // select work registers
  logic [WS_W-1:0]        wsum_q;
  logic [PW-1:0]          acc_q;
  logic [NUM_SLOTS-1:0]   used_q;
  logic [WS_W-1:0]        cum_q;
  logic [TD_W-1:0]        best_w_q;
  logic [FACE_BITS-1:0]   best_face_q;
  status_e                res_status_q;
  logic [FACE_BITS-1:0]   res_face_q;

  // output register
  logic                     m_valid_q;
  status_e                  m_status_q;
  logic [FACE_BITS-1:0]     m_face_q;
  logic [WSUM_OUT_BITS-1:0] m_wsum_q;

  // input field extraction, delay and random word cut to their used widths
  logic [DELAY_BITS+DELAY_IN_BITS-1:0] dly_ext;
  logic [RANDOM_BITS+RANDOM_IN_BITS-1:0] rnd_ext;
  logic [RND_W+RANDOM_BITS-1:0]          rnd_pad;
  assign dly_ext = {{DELAY_BITS{1'b0}}, s_tdata_i[OFS_DELAY +: DELAY_IN_BITS]};
  assign rnd_ext = {{RANDOM_BITS{1'b0}}, s_tdata_i[OFS_RND +: RANDOM_IN_BITS]};
  assign rnd_pad = {{RND_W{1'b0}}, rnd_ext[RANDOM_BITS-1:0]};

  // lookup of the face and the lowest free slot
  logic [NUM_SLOTS-1:0] hit;
  logic                 hit_any;
  logic [SLOT_W-1:0]    hit_idx;
  logic [NUM_SLOTS-1:0] free_vec, free_low;
  logic                 free_any;
  logic [SLOT_W-1:0]    free_idx;
  logic [DELAY_BITS-1:0] old_dly, new_dly;

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      hit[i] = valid_q[i] && (face_tab_q[i] == face_q);
    end
    free_vec = ~valid_q;
    free_low = free_vec & (~free_vec + 1'b1);
    for (int i = 0; i < NUM_SLOTS; i++) begin
      hit_idx  = hit_idx  | (hit[i]      ? SLOT_W'(i) : '0);
      free_idx = free_idx | (free_low[i] ? SLOT_W'(i) : '0);
    end
  end

  assign hit_any  = |hit;
  assign free_any = |free_vec;
  assign old_dly  = dly_q[hit_idx];
  assign new_dly  = (act_q == ACT_EXPIRE) ? {DELAY_BITS{1'b1}} : din_q;

  // weight sum: every present face weighs total minus its own delay
  logic [CNT_W-1:0]      cnt_m1;
  logic [CNT_W+TD_W-1:0] wprod;
  assign cnt_m1 = (cnt_q == '0) ? '0 : cnt_q - 1'b1;
  assign wprod  = cnt_m1 * total_q;

  // random word times (weight sum + 1), one slice a cycle, top slice first
  logic [WS_W:0]              w1;
  logic [CHUNK_BITS-1:0]      chunk;
  logic [CHUNK_BITS+WS_W:0]   part;
  logic [WS_W-1:0]            sel;
  assign w1    = {1'b0, wsum_q} + 1'b1;
  assign chunk = rnd_q[RND_W-1 -: CHUNK_BITS];
  assign part  = chunk * w1;
  assign sel   = acc_q[RANDOM_BITS +: WS_W];

  // minimum tree over (delay, face) of the faces not yet walked
  logic                 nv   [2*P];
  logic [KEY_W-1:0]     nkey [2*P];
  logic [SLOT_W-1:0]    nidx [2*P];

  always_comb begin
    for (int k = 0; k < 2 * P; k++) begin
      nv[k]   = 1'b0;
      nkey[k] = '0;
      nidx[k] = '0;
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      nv[P+i]   = valid_q[i] && !used_q[i];
      nkey[P+i] = {dly_q[i], face_tab_q[i]};
      nidx[P+i] = SLOT_W'(i);
    end
    for (int k = P - 1; k >= 1; k--) begin
      if (nv[2*k] && (!nv[2*k+1] || (nkey[2*k] < nkey[2*k+1]))) begin
        nkey[k] = nkey[2*k];
        nidx[k] = nidx[2*k];
      end else begin
        nkey[k] = nkey[2*k+1];
        nidx[k] = nidx[2*k+1];
      end
      nv[k] = nv[2*k] || nv[2*k+1];
    end
  end

  logic [DELAY_BITS-1:0] best_dly;
  logic [FACE_BITS-1:0]  best_face;
  logic [WS_W-1:0]       cum_d;
  logic                  found;
  assign best_dly  = nkey[1][KEY_W-1:FACE_BITS];
  assign best_face = nkey[1][FACE_BITS-1:0];
  assign cum_d     = cum_q + WS_W'(best_w_q);
  assign found     = (sel <= cum_d) && mask_q[best_face_q];

  logic [WS_W+WSUM_OUT_BITS-1:0] wsum_ext;
  assign wsum_ext = {{WSUM_OUT_BITS{1'b0}}, wsum_q};

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      total_q   <= '0;
      cnt_q     <= '0;
      used_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (cmd_i.apply) begin
        case (act_q)
          ACT_ADD: begin
            if (!hit_any && free_any) begin
              valid_q[free_idx] <= 1'b1;
              cnt_q             <= cnt_q + 1'b1;
            end
          end
          ACT_REMOVE: begin
            if (hit_any) begin
              valid_q[hit_idx] <= 1'b0;
              cnt_q            <= cnt_q - 1'b1;
              total_q          <= total_q - TD_W'(old_dly);
            end
          end
          ACT_RECORD, ACT_EXPIRE: begin
            if (hit_any) begin
              total_q <= total_q - TD_W'(old_dly) + TD_W'(new_dly);
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd_i.wsum) begin
        used_q <= '0;
      end
      if (cmd_i.pick && nv[1]) begin
        used_q[nidx[1]] <= 1'b1;
      end
      if (cmd_i.out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= action_e'(s_tuser_i);
      face_q <= s_tdata_i[OFS_FACE +: FACE_BITS];
      din_q  <= dly_ext[DELAY_BITS-1:0];
      mask_q <= s_tdata_i[OFS_MASK +: MASK_BITS];
      rnd_q  <= rnd_pad[RND_W-1:0];
    end
    if (cmd_i.apply) begin
      res_status_q <= STAT_OK;
      res_face_q   <= '0;
      case (act_q)
        ACT_ADD: begin
          if (!hit_any) begin
            if (free_any) begin
              face_tab_q[free_idx] <= face_q;
              dly_q[free_idx]      <= '0;
            end else begin
              res_status_q <= STAT_FULL;
            end
          end
        end
        ACT_REMOVE: begin
          if (!hit_any) begin
            res_status_q <= STAT_ABSENT;
          end
        end
        ACT_RECORD, ACT_EXPIRE: begin
          if (hit_any) begin
            dly_q[hit_idx] <= new_dly;
          end else begin
            res_status_q <= STAT_ABSENT;
          end
        end
        ACT_SELECT: begin
          res_status_q <= STAT_NONE;
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.wsum) begin
      wsum_q <= WS_W'(wprod);
      acc_q  <= '0;
      cum_q  <= '0;
    end
    if (cmd_i.mul_step) begin
      acc_q <= (acc_q << CHUNK_BITS) + PW'(part);
      rnd_q <= rnd_q << CHUNK_BITS;
    end
    if (cmd_i.pick) begin
      best_w_q    <= total_q - TD_W'(best_dly);
      best_face_q <= best_face;
    end
    if (cmd_i.acc) begin
      cum_q <= cum_d;
      if (found) begin
        res_status_q <= STAT_OK;
        res_face_q   <= best_face_q;
      end
    end
    if (cmd_i.out_load) begin
      m_status_q <= res_status_q;
      m_face_q   <= res_face_q;
      m_wsum_q   <= wsum_ext[WSUM_OUT_BITS-1:0];
    end
  end

  assign stat_o.is_select = (act_q == ACT_SELECT);
  assign stat_o.pick_none = !nv[1];
  assign stat_o.found     = found;
  assign stat_o.out_free  = !m_valid_q || m_tready_i;

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = {{(M_TDATA_W - M_TDATA_RAW){1'b0}}, m_wsum_q, m_face_q};
  assign m_tuser_o  = m_status_q;

endmodule

`default_nettype wire

// ===== hw/rtl/dwfs_checker.sv =====
`default_nettype none

module dwfs_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [dwfs_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input wire logic [dwfs_pkg::M_TUSER_W-1:0] m_axis_tuser
);
  import dwfs_pkg::*;

  logic       s_xfer, m_xfer;
  logic [1:0] pend_q;

  assign s_xfer = s_axis_tvalid && s_axis_tready;
  assign m_xfer = m_axis_tvalid && m_axis_tready;

  // items taken in but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {1'b0, s_xfer} - {1'b0, m_xfer};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != 2'd0)
    else $error("result without an outstanding item");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 2'd2 |-> !s_axis_tready && pend_q != 2'd3)
    else $error("input taken with a result parked and one in flight");

  a_chosen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != STAT_OK) |-> m_axis_tdata[FACE_BITS-1:0] == '0)
    else $error("chosen face set on a failed item");

endmodule

bind delay_weighted_face_selector_unit dwfs_checker u_dwfs_checker (.*);

`default_nettype wire
